FILE: rtl/nrrs_pkg.sv
// Shared types and constants for the node range run splitter.
// Used by nrrs_front, nrrs_back, nrrs_out_queue and node_range_run_splitter.
package nrrs_pkg;

  localparam int NODE_W   = 8;
  localparam int IDX_W    = 24;
  localparam int NUM_W    = 6;
  localparam int BUDGET_W = 9;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 9'd64;
  localparam logic [IDX_W-1:0]    TRI_INDICES  = 24'd3;

  localparam logic OP_TRIANGLE  = 1'b0;
  localparam logic OP_NEW_MODEL = 1'b1;

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_MISFIT   = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] tlo;
    logic [NODE_W-1:0] thi;
    logic [IDX_W-1:0]  pos;
    logic              batch_end;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  run_first;
    logic [IDX_W-1:0]  run_length;
    logic [NODE_W-1:0] span_low;
    logic [NODE_W-1:0] span_high;
    logic [NUM_W-1:0]  run_number;
    logic              last;
  } res_t;

endpackage

FILE: rtl/nrrs_front.sv
// Front end: accepts input requests, reduces the three corners to a node span
// and holds the classified triangle in a two-entry command queue. Uses nrrs_pkg.
module nrrs_front import nrrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [NODE_W-1:0] corner_node_a,
  input  logic [NODE_W-1:0] corner_node_b,
  input  logic [NODE_W-1:0] corner_node_c,
  input  logic [IDX_W-1:0]  index_pos,
  input  logic              batch_end,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_take
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       accept;
  logic [NODE_W-1:0] ab_lo, ab_hi;
  cmd_t       cmd_in;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = mem[rd_ptr];

  always_comb begin
    ab_lo = (corner_node_a < corner_node_b) ? corner_node_a : corner_node_b;
    ab_hi = (corner_node_a > corner_node_b) ? corner_node_a : corner_node_b;
    cmd_in.op        = op;
    cmd_in.tlo       = (ab_lo < corner_node_c) ? ab_lo : corner_node_c;
    cmd_in.thi       = (ab_hi > corner_node_c) ? ab_hi : corner_node_c;
    cmd_in.pos       = index_pos;
    cmd_in.batch_end = batch_end;
  end

  always_comb begin
    count_next = count;
    case ({accept, cmd_take})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (accept && !cmd_take) |=> (count == $past(count) + 2'd1))
    else $error("command queue count lost a request");

endmodule

FILE: rtl/nrrs_back.sv
// Back end: run state, node budget register and the split decision; turns one
// command into zero, one or two results. Uses nrrs_pkg.
module nrrs_back import nrrs_pkg::*; #(
  parameter int MAX_RUNS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                node_budget_we,
  input  logic [BUDGET_W-1:0] node_budget,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_take,
  input  logic                room,
  output logic [1:0]          res_n,
  output res_t                res0,
  output res_t                res1
);

  localparam int TOTAL_W = $clog2(MAX_RUNS + 1);
  localparam logic [TOTAL_W-1:0] MAX_T = TOTAL_W'(MAX_RUNS);

  logic [BUDGET_W-1:0] budget;
  logic                run_open, run_open_next;
  logic [NODE_W-1:0]   run_low, run_low_next;
  logic [NODE_W-1:0]   run_high, run_high_next;
  logic [IDX_W-1:0]    run_start, run_start_next;
  logic [IDX_W-1:0]    run_indices, run_indices_next;
  logic [TOTAL_W-1:0]  run_total, run_total_next;
  logic                failed, failed_next;

  logic [NODE_W-1:0]      wl, wh;
  logic                   fit_run, fit_tri, done, taken;
  logic [TOTAL_W+NUM_W-1:0] num_ext;
  res_t                   res [2];
  logic [1:0]             n;

  assign cmd_take = cmd_valid && room;

  always_comb begin
    wl = (cmd.tlo < run_low) ? cmd.tlo : run_low;
    wh = (cmd.thi > run_high) ? cmd.thi : run_high;
    fit_run = {1'b0, wh - wl} < budget;
    fit_tri = {1'b0, cmd.thi - cmd.tlo} < budget;
  end

  always_comb begin
    run_open_next    = run_open;
    run_low_next     = run_low;
    run_high_next    = run_high;
    run_start_next   = run_start;
    run_indices_next = run_indices;
    run_total_next   = run_total;
    failed_next      = failed;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    done    = 1'b0;
    taken   = 1'b0;
    num_ext = '0;
    if (cmd_take) begin
      if (cmd.op == OP_NEW_MODEL) begin
        run_total_next = '0;
        failed_next    = 1'b0;
        run_open_next  = 1'b0;
      end else if (!failed) begin
        if (run_open) begin
          if (fit_run) begin
            run_low_next     = wl;
            run_high_next    = wh;
            run_indices_next = run_indices + TRI_INDICES;
            taken            = 1'b1;
          end else begin
            res[0].run_first  = run_start;
            res[0].run_length = run_indices;
            res[0].span_low   = run_low;
            res[0].span_high  = run_high;
            n             = 2'd1;
            run_open_next = 1'b0;
            if (run_total >= MAX_T) begin
              res[0].kind = KIND_OVERFLOW;
              failed_next = 1'b1;
              done        = 1'b1;
            end else begin
              num_ext            = {{NUM_W{1'b0}}, run_total};
              res[0].kind        = KIND_RUN;
              res[0].run_number  = num_ext[NUM_W-1:0];
              run_total_next     = run_total + TOTAL_W'(1);
            end
          end
        end
        if (!done && !taken) begin
          if (!fit_tri) begin
            res[n[0]].kind       = KIND_MISFIT;
            res[n[0]].run_first  = cmd.pos;
            res[n[0]].run_length = TRI_INDICES;
            res[n[0]].span_low   = cmd.tlo;
            res[n[0]].span_high  = cmd.thi;
            n             = n + 2'd1;
            failed_next   = 1'b1;
            run_open_next = 1'b0;
            done          = 1'b1;
          end else begin
            run_open_next    = 1'b1;
            run_start_next   = cmd.pos;
            run_indices_next = TRI_INDICES;
            run_low_next     = cmd.tlo;
            run_high_next    = cmd.thi;
          end
        end
        if (!done && cmd.batch_end && run_open_next) begin
          res[n[0]].run_first  = run_start_next;
          res[n[0]].run_length = run_indices_next;
          res[n[0]].span_low   = run_low_next;
          res[n[0]].span_high  = run_high_next;
          run_open_next = 1'b0;
          if (run_total_next >= MAX_T) begin
            res[n[0]].kind = KIND_OVERFLOW;
            failed_next    = 1'b1;
          end else begin
            num_ext               = {{NUM_W{1'b0}}, run_total_next};
            res[n[0]].kind        = KIND_RUN;
            res[n[0]].run_number  = num_ext[NUM_W-1:0];
            run_total_next        = run_total_next + TOTAL_W'(1);
          end
          n = n + 2'd1;
        end
      end
    end
    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign res_n = n;
  assign res0  = res[0];
  assign res1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= BUDGET_RESET;
      run_open  <= 1'b0;
      run_low   <= '0;
      run_high  <= '0;
      run_start <= '0;
      run_indices <= '0;
      run_total <= '0;
      failed    <= 1'b0;
    end else begin
      if (node_budget_we) begin
        budget <= node_budget;
      end
      run_open    <= run_open_next;
      run_low     <= run_low_next;
      run_high    <= run_high_next;
      run_start   <= run_start_next;
      run_indices <= run_indices_next;
      run_total   <= run_total_next;
      failed      <= failed_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd_take && failed && cmd.op == OP_TRIANGLE) |-> (res_n == 2'd0))
    else $error("result after failure");
  assert property (@(posedge clk) disable iff (rst)
    (res_n == 2'd2) |-> (!res0.last && res1.last))
    else $error("last flag misplaced on result pair");
  assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.op == OP_NEW_MODEL) |=> (run_total == '0 && !failed && !run_open))
    else $error("new model did not clear run state");
  assert property (@(posedge clk) disable iff (rst) run_total <= MAX_T)
    else $error("run total beyond limit");

endmodule

FILE: rtl/nrrs_out_queue.sv
// Result queue: four entries, up to two writes and one read per cycle.
// Uses nrrs_pkg.
module nrrs_out_queue import nrrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] res_n,
  input  res_t       res0,
  input  res_t       res1,
  output logic       room,
  output logic       empty,
  input  logic       pop,
  output res_t       head
);

  res_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       take;

  assign empty = (count == 3'd0);
  assign room  = (count <= 3'd2);
  assign take  = pop && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + res_n;
      count  <= count + {1'b0, res_n} - {2'b00, take};
      if (take) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      mem[wr_ptr] <= res0;
    end
    if (res_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= res1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst) (res_n != 2'd0) |-> room)
    else $error("results written without room");
  assert property (@(posedge clk) disable iff (rst) res_n != 2'd3)
    else $error("bad result count");

endmodule

FILE: rtl/node_range_run_splitter.sv
// Top level of the node range run splitter: front end, back end, result queue.
// Uses nrrs_pkg, nrrs_front, nrrs_back, nrrs_out_queue.
//
//   channel   handshake          payload
//   input     push / full        op, corner_node_a/b/c, index_pos, batch_end
//   result    empty / pop        kind, run_first, run_length, span_low,
//                                span_high, run_number, last
//   config    node_budget_we     node_budget
//
// One request per cycle sustained while the result queue has room; a request's
// results pass through the command queue, then the result queue, before they
// can be popped from the result ports. The back end takes a command only when
// the result queue has two free slots, so output stalls back up through the
// command queue to full. Reset: synchronous, no clearing pass.
module node_range_run_splitter import nrrs_pkg::*; #(
  parameter int MAX_RUNS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic [NODE_W-1:0]   corner_node_a,
  input  logic [NODE_W-1:0]   corner_node_b,
  input  logic [NODE_W-1:0]   corner_node_c,
  input  logic [IDX_W-1:0]    index_pos,
  input  logic                batch_end,
  input  logic                node_budget_we,
  input  logic [BUDGET_W-1:0] node_budget,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind,
  output logic [IDX_W-1:0]    run_first,
  output logic [IDX_W-1:0]    run_length,
  output logic [NODE_W-1:0]   span_low,
  output logic [NODE_W-1:0]   span_high,
  output logic [NUM_W-1:0]    run_number,
  output logic                last
);

  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;
  logic       room;
  logic [1:0] res_n;
  res_t       res0;
  res_t       res1;
  res_t       head;

  nrrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .op            (op),
    .corner_node_a (corner_node_a),
    .corner_node_b (corner_node_b),
    .corner_node_c (corner_node_c),
    .index_pos     (index_pos),
    .batch_end     (batch_end),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  nrrs_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .node_budget_we (node_budget_we),
    .node_budget    (node_budget),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .room           (room),
    .res_n          (res_n),
    .res0           (res0),
    .res1           (res1)
  );

  nrrs_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .res_n (res_n),
    .res0  (res0),
    .res1  (res1),
    .room  (room),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign kind       = head.kind;
  assign run_first  = head.run_first;
  assign run_length = head.run_length;
  assign span_low   = head.span_low;
  assign span_high  = head.span_high;
  assign run_number = head.run_number;
  assign last       = head.last;

endmodule

FILE: tb/sv/tb_node_range_run_splitter.sv
// Self-checking testbench for node_range_run_splitter: a run-list tracker
// predicts every result from the accepted requests and checks the result queue.
// Depends on rtl/nrrs_pkg.sv and rtl/node_range_run_splitter.sv.
module tb_node_range_run_splitter import nrrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 11;

  class run_list_tracker;
    int                  run_limit;
    logic [BUDGET_W-1:0] budget;
    bit                  open, halted;
    logic [NODE_W-1:0]   lo, hi;
    logic [IDX_W-1:0]    first, count;
    int                  total, mismatches, checked;
    int                  kind_seen[3];
    res_t                expected_runs[$];

    function new(int limit);
      run_limit = limit;
      budget = BUDGET_RESET;
      open = 0;
      halted = 0;
      lo = '0;
      hi = '0;
      first = '0;
      count = '0;
      total = 0;
      mismatches = 0;
      checked = 0;
      kind_seen = '{0, 0, 0};
    endfunction

    // closes the open run; 0 when the run list is already full
    function bit store_run();
      res_t r;
      r.run_first = first;
      r.run_length = count;
      r.span_low = lo;
      r.span_high = hi;
      r.last = 1'b0;
      open = 0;
      if (total >= run_limit) begin
        r.kind = KIND_OVERFLOW;
        r.run_number = '0;
        halted = 1;
      end else begin
        r.kind = KIND_RUN;
        r.run_number = NUM_W'(total);
        total++;
      end
      expected_runs.push_back(r);
      return !halted;
    endfunction

    function void flag_last(int base_n);
      if (expected_runs.size() > base_n)
        expected_runs[expected_runs.size() - 1].last = 1'b1;
    endfunction

    function void note_request(logic op_i, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                               logic [NODE_W-1:0] nc, logic [IDX_W-1:0] pos, logic end_i);
      logic [NODE_W-1:0] tlo, thi, wl, wh;
      res_t r;
      int base_n;
      bit taken;
      base_n = expected_runs.size();
      taken = 0;
      if (op_i == OP_NEW_MODEL) begin
        total = 0;
        halted = 0;
        open = 0;
        return;
      end
      if (halted) return;
      tlo = na;
      if (nb < tlo) tlo = nb;
      if (nc < tlo) tlo = nc;
      thi = na;
      if (nb > thi) thi = nb;
      if (nc > thi) thi = nc;
      if (open) begin
        wl = (tlo < lo) ? tlo : lo;
        wh = (thi > hi) ? thi : hi;
        if (int'(wh) - int'(wl) < int'(budget)) begin
          lo = wl;
          hi = wh;
          count += TRI_INDICES;
          taken = 1;
        end else if (!store_run()) begin
          flag_last(base_n);
          return;
        end
      end
      if (!taken) begin
        if (int'(thi) - int'(tlo) >= int'(budget)) begin
          r.kind = KIND_MISFIT;
          r.run_first = pos;
          r.run_length = TRI_INDICES;
          r.span_low = tlo;
          r.span_high = thi;
          r.run_number = '0;
          r.last = 1'b0;
          expected_runs.push_back(r);
          halted = 1;
          open = 0;
          flag_last(base_n);
          return;
        end
        open = 1;
        first = pos;
        count = TRI_INDICES;
        lo = tlo;
        hi = thi;
      end
      if (end_i && open) void'(store_run());
      flag_last(base_n);
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [1:0] k, logic [IDX_W-1:0] f, logic [IDX_W-1:0] l,
                               logic [NODE_W-1:0] sl, logic [NODE_W-1:0] sh,
                               logic [NUM_W-1:0] rn, logic lst);
      res_t e;
      if (expected_runs.size() == 0) begin
        $error("unexpected result: kind %0h run_first %0h", k, f);
        mismatches++;
        return;
      end
      e = expected_runs.pop_front();
      checked++;
      if (!$isunknown(k) && k < 3) kind_seen[k]++;
      field_ok("kind", e.kind, k);
      field_ok("run_first", e.run_first, f);
      field_ok("run_length", e.run_length, l);
      field_ok("span_low", e.span_low, sl);
      field_ok("span_high", e.span_high, sh);
      field_ok("run_number", e.run_number, rn);
      field_ok("last", e.last, lst);
    endfunction
  endclass

  logic                clk, rst, push, full, op, batch_end, node_budget_we, empty, pop, last;
  logic [NODE_W-1:0]   corner_node_a, corner_node_b, corner_node_c, span_low, span_high;
  logic [IDX_W-1:0]    index_pos, run_first, run_length;
  logic [BUDGET_W-1:0] node_budget;
  logic [1:0]          kind;
  logic [NUM_W-1:0]    run_number;

  run_list_tracker tracker = new(RUN_LIMIT);

  bit              send_gaps = 1, pop_gaps = 1, hold_request = 0;
  int              accepted = 0, stalled_cycles = 0, center = 128;
  logic [IDX_W-1:0] next_pos;

  int plan_budget[PHASES] = '{1, 2, 0, 255, 256, 511, 16, 64, 100, -1, 40};
  int plan_items[PHASES]  = '{100, 100, 60, 100, 150, 100, 120, 120, 120, 120, 150};
  int plan_end[PHASES]    = '{15, 15, 10, 10, 90, 20, 12, 12, 12, 12, 85};
  int plan_model[PHASES]  = '{3, 3, 3, 2, 0, 2, 3, 3, 3, 3, 0};
  int plan_wide[PHASES]   = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 0};

  node_range_run_splitter #(.MAX_RUNS(RUN_LIMIT)) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20ms);
    $display("FAIL node_range_run_splitter");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge; push stays high for a following request
  task automatic send_request(logic o, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                              logic [NODE_W-1:0] nc, logic [IDX_W-1:0] pos, logic be);
    int gap;
    gap = send_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = o;
    corner_node_a = na;
    corner_node_b = nb;
    corner_node_c = nc;
    index_pos = pos;
    batch_end = be;
    push = 1'b1;
    @(posedge clk);
    while (full) begin
      stalled_cycles++;
      @(posedge clk);
    end
    tracker.note_request(o, na, nb, nc, pos, be);
    accepted++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (tracker.expected_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_budget(logic [BUDGET_W-1:0] v);
    node_budget = v;
    node_budget_we = 1'b1;
    @(negedge clk);
    node_budget_we = 1'b0;
    tracker.budget = v;
  endtask

  task automatic run_phase(int n_items, int end_pct, int model_pct, int wide_pct);
    int counted, half, s, v;
    logic [NODE_W-1:0] nd[3];
    logic o;
    counted = 0;
    half = int'(tracker.budget) / 2;
    if (half > 255) half = 255;
    while (counted < n_items) begin
      o = OP_TRIANGLE;
      if (tracker.halted ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 99) < model_pct))
        o = OP_NEW_MODEL;
      if (o == OP_NEW_MODEL || !tracker.halted) counted++;
      if (o == OP_NEW_MODEL) begin
        send_request(o, 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom),
                     1'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) center = $urandom_range(0, 255);
        s = ($urandom_range(0, 99) < wide_pct) ? 255 : $urandom_range(0, half);
        for (int i = 0; i < 3; i++) begin
          v = center + int'($urandom_range(0, s)) - s / 2;
          if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 255);
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          nd[i] = NODE_W'(v);
        end
        if ($urandom_range(0, 15) == 0) next_pos = 24'($urandom);
        send_request(o, nd[0], nd[1], nd[2], next_pos, $urandom_range(0, 99) < end_pct);
        next_pos += TRI_INDICES;
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    pop = 1'b0;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (pop_gaps) stall_left = idle_gap();
      end
      @(posedge clk);
      if (pop && !empty)
        tracker.check_result(kind, run_first, run_length, span_low, span_high, run_number, last);
    end
  end

  initial begin
    int b;
    rst = 1'b1;
    push = 1'b0;
    op = OP_TRIANGLE;
    corner_node_a = '0;
    corner_node_b = '0;
    corner_node_c = '0;
    index_pos = '0;
    batch_end = 1'b0;
    node_budget_we = 1'b0;
    node_budget = '0;
    next_pos = 24'($urandom);
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed, at the reset budget of 64
    send_request(OP_TRIANGLE, 8'd0, 8'd0, 8'd0, 24'h000000, 1'b0);
    send_request(OP_TRIANGLE, 8'd63, 8'd1, 8'd30, 24'h000003, 1'b0);
    send_request(OP_TRIANGLE, 8'd64, 8'd64, 8'd64, 24'h000006, 1'b0);
    send_request(OP_TRIANGLE, 8'd255, 8'd255, 8'd255, 24'h000009, 1'b1);
    send_request(OP_TRIANGLE, 8'd10, 8'd20, 8'd30, 24'hFFFFF0, 1'b0);
    send_request(OP_TRIANGLE, 8'd40, 8'd41, 8'd73, 24'hFFFFF3, 1'b1);
    send_request(OP_TRIANGLE, 8'd5, 8'd5, 8'd5, 24'h000100, 1'b0);
    send_request(OP_TRIANGLE, 8'd0, 8'd255, 8'd128, 24'h000103, 1'b0);
    send_request(OP_TRIANGLE, 8'd1, 8'd2, 8'd3, 24'h000106, 1'b1);
    send_request(OP_NEW_MODEL, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1);
    send_request(OP_TRIANGLE, 8'd0, 8'd64, 8'd32, 24'hFFFFFF, 1'b1);
    send_request(OP_TRIANGLE, 8'd9, 8'd9, 8'd9, 24'h000000, 1'b1);
    send_request(OP_NEW_MODEL, 8'h00, 8'h00, 8'h00, 24'h000000, 1'b0);
    send_request(OP_TRIANGLE, 8'd200, 8'd210, 8'd220, 24'h000050, 1'b0);
    send_request(OP_NEW_MODEL, 8'h01, 8'h01, 8'h01, 24'h000001, 1'b1);
    send_request(OP_TRIANGLE, 8'd130, 8'd170, 8'd150, 24'hAAAAAA, 1'b1);
    send_request(OP_TRIANGLE, 8'h55, 8'hAA, 8'h80, 24'h555555, 1'b0);
    send_request(OP_NEW_MODEL, 8'hAA, 8'h55, 8'hAA, 24'h555555, 1'b0);
    send_request(OP_TRIANGLE, 8'd255, 8'd192, 8'd255, 24'hFFFFFD, 1'b0);
    send_request(OP_TRIANGLE, 8'd255, 8'd255, 8'd255, 24'h000000, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      b = (plan_budget[p] < 0) ? $urandom_range(1, 256) : plan_budget[p];
      set_budget(BUDGET_W'(b));
      send_gaps = ($urandom_range(0, 3) != 0);
      pop_gaps = ($urandom_range(0, 3) != 0);
      if (p == 6) begin
        send_gaps = 0;
        hold_request = 1;
      end
      run_phase(plan_items[p], plan_end[p], plan_model[p], plan_wide[p]);
      wait_drained();
    end
    repeat (12) @(negedge clk);

    $display("Run covered %0d requests over %0d budget settings, %0d input stall cycles",
             accepted, PHASES + 1, stalled_cycles);
    $display("Checked %0d results: %0d runs, %0d misfits, %0d run-list overflows",
             tracker.checked, tracker.kind_seen[0], tracker.kind_seen[1], tracker.kind_seen[2]);
    if (tracker.mismatches == 0 && tracker.expected_runs.size() == 0) begin
      $display("PASS node_range_run_splitter");
    end else begin
      $display("FAIL node_range_run_splitter");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/nrrs_pkg.sv
rtl/nrrs_front.sv
rtl/nrrs_back.sv
rtl/nrrs_out_queue.sv
rtl/node_range_run_splitter.sv
tb/sv/tb_node_range_run_splitter.sv
